FILE: hw/rtl/linear_probing_hash_table_assert.svh
// Assertion macros for the linear probing hash table checker.
// Used by lpht_checker.sv; no other dependencies.
`ifndef LINEAR_PROBING_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lpht_pkg.sv
// Shared types, constants and helpers for the linear probing hash table.
// No dependencies.
`default_nettype none

package lpht_pkg;

    // Table geometry
    localparam int SLOT_BITS     = 10;
    localparam int SLOT_COUNT    = 1 << SLOT_BITS;
    localparam int ROW_BITS      = (SLOT_BITS > 5) ? 5 : SLOT_BITS - 1;
    localparam int ROW_W         = 1 << ROW_BITS;
    localparam int ROW_ADDR_BITS = SLOT_BITS - ROW_BITS;
    localparam int VALUE_W       = 63;
    localparam int INDEX_W       = 10;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Status codes
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [VALUE_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] slot_index;
        logic [VALUE_W-1:0] read_value;
    } t_out;

    typedef struct packed {
        logic                     en;
        logic [ROW_ADDR_BITS-1:0] addr;
        logic [ROW_W-1:0]         data;
    } t_occ_wr;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        logic [VALUE_W-1:0]   data;
    } t_val_wr;

    // Fit a slot number into the output index field
    function automatic logic [INDEX_W-1:0] to_index(input logic [SLOT_BITS-1:0] slot);
        logic [SLOT_BITS+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, slot};
        return wide[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lpht_occ_mem.sv
// Occupancy bitmap memory, one row of slot bits per word, registered read.
// Depends on lpht_pkg.
`default_nettype none

module lpht_occ_mem (
    input  wire                               i_clk,
    input  wire [lpht_pkg::ROW_ADDR_BITS-1:0] i_rd_addr,
    output logic [lpht_pkg::ROW_W-1:0]        o_rd_data,
    input  lpht_pkg::t_occ_wr                 i_wr
);
    import lpht_pkg::*;

    logic [ROW_W-1:0] mem [1 << ROW_ADDR_BITS];

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_val_mem.sv
// Slot value memory, one value per slot, registered read.
// Depends on lpht_pkg.
`default_nettype none

module lpht_val_mem (
    input  wire                           i_clk,
    input  wire [lpht_pkg::SLOT_BITS-1:0] i_rd_addr,
    output logic [lpht_pkg::VALUE_W-1:0]  o_rd_data,
    input  lpht_pkg::t_val_wr             i_wr
);
    import lpht_pkg::*;

    logic [VALUE_W-1:0] mem [SLOT_COUNT];

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probing_hash_table.sv
// Linear probing hash table with 2^SLOT_BITS slots of 63-bit values. A read
// passes from acceptance through S_EVAL and S_OUT into the output register.
// An insert into a table that is not full scans the 32-slot occupancy rows
// from the home row, skipping slots below the home slot on the first visit,
// and wraps; it stays in the home row when that row has a free slot at or
// after the home slot, and else may visit every row and the home row again.
// The scan reads one row at a time through the single read port of the
// occupancy memory. One word is in work at a time; the next is taken as soon
// as the previous result sits in the output register, and a result waits in
// S_OUT while the output is stalled. After reset the block clears every
// occupancy row before it takes the first word. Depends on lpht_pkg, lpht_occ_mem and lpht_val_mem.
`default_nettype none

module linear_probing_hash_table (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  lpht_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output lpht_pkg::t_out o_out_data
);
    import lpht_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [ROW_ADDR_BITS-1:0] r_clr_row;
    logic                     r_req;
    logic [VALUE_W-1:0]       r_val;
    logic [ROW_ADDR_BITS-1:0] r_row, n_row;
    logic                     r_first, n_first;
    logic [SLOT_BITS:0]       r_count, n_count;
    t_out                     r_res, n_res;
    logic                     r_ovalid;
    t_out                     r_odata;

    logic [ROW_ADDR_BITS-1:0] occ_rd_addr;
    logic [ROW_W-1:0]         occ_rd_data;
    logic [SLOT_BITS-1:0]     val_rd_addr;
    logic [VALUE_W-1:0]       val_rd_data;
    t_occ_wr                  occ_wr;
    t_val_wr                  val_wr;

    logic                     accept;
    logic [ROW_BITS-1:0]      home_off;
    logic [ROW_ADDR_BITS-1:0] home_row;
    logic [ROW_W-1:0]         avail;
    logic                     found;
    logic [ROW_BITS-1:0]      pos;
    logic                     out_free;

    lpht_occ_mem u_occ (
        .i_clk     (i_clk),
        .i_rd_addr (occ_rd_addr),
        .o_rd_data (occ_rd_data),
        .i_wr      (occ_wr)
    );

    lpht_val_mem u_val (
        .i_clk     (i_clk),
        .i_rd_addr (val_rd_addr),
        .o_rd_data (val_rd_data),
        .i_wr      (val_wr)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign home_off = r_val[ROW_BITS-1:0];
    assign home_row = r_val[SLOT_BITS-1:ROW_BITS];

    // Issue reads: home slot on accept, next row while scanning
    always_comb begin
        if (r_state == S_EVAL) begin
            occ_rd_addr = r_row + 1'b1;
        end else begin
            occ_rd_addr = i_in_data.item_value[SLOT_BITS-1:ROW_BITS];
        end
        val_rd_addr = i_in_data.item_value[SLOT_BITS-1:0];
    end

    // Find the lowest free slot in the row, skipping slots below home on first visit
    always_comb begin
        avail = ~occ_rd_data;
        if (r_first) begin
            avail = avail & ({ROW_W{1'b1}} << home_off);
        end
        found = |avail;
        pos   = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pos = ROW_BITS'(i);
            end
        end
    end

    // Sequence the lookup and the probe
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_first = r_first;
        n_count = r_count;
        n_res   = r_res;
        occ_wr  = '{en: 1'b0, addr: r_row, data: occ_rd_data | (ROW_W'(1) << pos)};
        val_wr  = '{en: 1'b0, addr: {r_row, pos}, data: r_val};
        unique case (r_state)
            S_CLEAR: begin
                occ_wr = '{en: 1'b1, addr: r_clr_row, data: '0};
                if (r_clr_row == {ROW_ADDR_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                    n_row   = i_in_data.item_value[SLOT_BITS-1:ROW_BITS];
                    n_first = 1'b1;
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (r_req == REQ_READ) begin
                    if (occ_rd_data[home_off]) begin
                        n_res = '{status: ST_HIT, slot_index: to_index(r_val[SLOT_BITS-1:0]),
                                  read_value: val_rd_data};
                    end else begin
                        n_res = '{status: ST_MISS, slot_index: to_index(r_val[SLOT_BITS-1:0]),
                                  read_value: '0};
                    end
                end else if (r_count[SLOT_BITS]) begin
                    n_res = '{status: ST_FULL, slot_index: to_index(r_val[SLOT_BITS-1:0]),
                              read_value: '0};
                end else if (found) begin
                    occ_wr.en = 1'b1;
                    val_wr.en = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_res     = '{status: ST_INS, slot_index: to_index({r_row, pos}),
                                  read_value: '0};
                end else begin
                    // advance to the next row, wrapping; a free slot is known to exist
                    n_state = S_EVAL;
                    n_row   = r_row + 1'b1;
                    n_first = 1'b0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data.req_type;
            r_val <= i_in_data.item_value;
        end
        r_row   <= n_row;
        r_first <= n_first;
        r_res   <= n_res;
        if (r_state == S_OUT && out_free) begin
            r_odata <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_checker.sv
// Port-level checker for the linear probing hash table, bound to the top level.
// Depends on lpht_pkg and linear_probing_hash_table_assert.svh.
`default_nettype none

`include "linear_probing_hash_table_assert.svh"

module lpht_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_stall,
    input lpht_pkg::t_in  i_in_data,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input lpht_pkg::t_out o_out_data
);
    import lpht_pkg::*;

    // A stalled result word holds
    `LPHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output word changed")

    // Only a hit carries a value
    `LPHT_ASSERT_NOW(a_value_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_HIT), o_out_data.read_value == '0, "nonzero value without a hit")

    // One word in work at a time
    `LPHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "block took a word while busy")

endmodule

bind linear_probing_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
